### rtl/core/graph_clustering_and_overlap_macros.svh
// assertion macros shared by the graph clustering and overlap rtl
`ifndef GRAPH_CLUSTERING_AND_OVERLAP_MACROS_SVH
`define GRAPH_CLUSTERING_AND_OVERLAP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define GCAO_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// condition holds in the cycle after the trigger
`define GCAO_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/gcao_pkg.sv
// shared types, constants and helpers for the graph clustering and overlap block
package gcao_pkg;

  localparam int ROW_W         = 64;
  localparam int NODE_W        = 6;
  localparam int CNT_W         = 7;
  localparam int NUM_W         = 11;
  localparam int SUM_W         = NUM_W + 1;
  localparam int DEG_W         = NODE_W + 1;
  localparam int RATIO_W       = 17;
  localparam int FRAC_BITS     = 16;
  localparam int STEP_W        = $clog2(FRAC_BITS);
  localparam int DIGIT_W       = 8;
  localparam int DIGITS        = ROW_W / DIGIT_W;
  localparam int DCNT_W        = $clog2(DIGITS);
  localparam int POP8_W        = 4;
  localparam int ROWCNT_W      = 7;
  localparam int MAX_NODES_DEF = 64;

  localparam logic [CNT_W-1:0]   NODE_COUNT_RST = CNT_W'(64);
  localparam logic [RATIO_W-1:0] Q_ONE          = RATIO_W'(65536);

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_CLUSTER = 2'd1;
  localparam logic [1:0] ACT_OVERLAP = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CL_ROW,
    ST_CL_WALK,
    ST_CL_DRAIN,
    ST_CL_FIN,
    ST_OV_ROWA,
    ST_OV_ROWB,
    ST_OV_COUNT,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [POP8_W-1:0] pop8(input logic [DIGIT_W-1:0] d);
    logic [POP8_W-1:0] c;
    c = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      c = c + POP8_W'(d[i]);
    end
    return c;
  endfunction

endpackage

### rtl/core/gcao_div.sv
// bit-serial restoring divider giving a saturated q1.16 ratio
`include "graph_clustering_and_overlap_macros.svh"

module gcao_div (
  input  logic               clk,
  input  logic               rst,
  input  gcao_pkg::div_req_t req,
  output gcao_pkg::div_rsp_t rsp
);
  import gcao_pkg::*;

  logic                 busy;
  logic [NUM_W:0]       rem;
  logic [NUM_W-1:0]     dvs;
  logic [FRAC_BITS-1:0] q;
  logic [STEP_W-1:0]    step;
  logic [NUM_W:0]       rem_sh;
  logic [NUM_W:0]       rem_next;
  logic [FRAC_BITS-1:0] q_next;

  always_comb begin
    rem_sh = {rem[NUM_W-1:0], 1'b0};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = rem_sh - {1'b0, dvs};
      q_next   = {q[FRAC_BITS-2:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      q_next   = {q[FRAC_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        dvs <= req.den;
        if (req.den == '0) begin
          rsp.quo  <= '0;
          rsp.done <= 1'b1;
        end else if (req.num >= req.den) begin
          rsp.quo  <= Q_ONE;
          rsp.done <= 1'b1;
        end else begin
          rem  <= {1'b0, req.num};
          q    <= '0;
          step <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= rem_next;
        q    <= q_next;
        step <= step + STEP_W'(1);
        if (step == STEP_W'(FRAC_BITS - 1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo  <= {1'b0, q_next};
        end
      end
    end
  end

  `GCAO_ASSERT_SAME(a_start_idle, clk, rst, req.start, !busy)
  `GCAO_ASSERT_SAME(a_quo_range, clk, rst, rsp.done, rsp.quo <= Q_ONE)
  `GCAO_ASSERT_NEXT(a_zero_den, clk, rst, req.start && req.den == '0, rsp.done && rsp.quo == '0)
  `GCAO_ASSERT_SAME(a_rem_below, clk, rst, busy, rem < {1'b0, dvs})

endmodule

### rtl/core/graph_clustering_and_overlap.sv
// Graph clustering and overlap engine. Adjacency rows live in a single-port
// MAX_NODES x 64 RAM with registered read. A load goes straight to the done state.
// A clustering query reads the node's row, then walks every row address once,
// one per cycle, through a 3-stage popcount pipeline, then runs the bit-serial
// divider (16 steps). An overlap query reads two rows, counts 8 bits per cycle
// and then runs the same divider. The row walk and the divider set the length
// of a query. One item is in work at a time; a finished result waits in the
// output register while the next item is accepted.
`include "graph_clustering_and_overlap_macros.svh"

module graph_clustering_and_overlap #(
  parameter int MAX_NODES = gcao_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gcao_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     action,
  input  logic [gcao_pkg::NODE_W-1:0]    node_a,
  input  logic [gcao_pkg::NODE_W-1:0]    node_b,
  input  logic [gcao_pkg::ROW_W-1:0]     row_bits,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gcao_pkg::NUM_W-1:0]     numerator,
  output logic [gcao_pkg::NUM_W-1:0]     denominator,
  output logic [gcao_pkg::RATIO_W-1:0]   ratio_q16
);
  import gcao_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam logic [AW-1:0] V_LAST = AW'(MAX_NODES - 1);
  // last drain count of the popcount pipeline after the last row read
  localparam logic [DCNT_W-1:0] DRAIN_LAST = DCNT_W'(2);

  state_t state, state_next;

  logic [CNT_W-1:0]     node_count;
  logic [CNT_W-1:0]     n_act;
  logic [ROW_W-1:0]     mask;
  logic                 load_ok, a_ok, b_ok;

  logic [ROW_W-1:0]     mem [MAX_NODES];
  logic                 mem_we;
  logic [AW-1:0]        rd_addr;
  logic [ROW_W-1:0]     rd_data;

  logic [NODE_W-1:0]    a_r, b_r;
  logic [ROW_W-1:0]     mask_r;
  logic [ROW_W-1:0]     onehot_a, pair, rb_c;
  logic [MAX_NODES-1:0] nb;
  logic [AW-1:0]        v;
  logic [DEG_W-1:0]     deg, deg_m1;
  logic [2*DEG_W-1:0]   prod;
  logic [SUM_W-1:0]     sum;
  logic [DCNT_W-1:0]    cnt;
  logic [ROW_W-1:0]     ra, w_and, w_or;
  logic [NUM_W-1:0]     num_r, den_r;
  logic [RATIO_W-1:0]   ratio_r;
  logic                 out_load;

  logic                 p0_flag, p1_flag, p2_flag;
  logic [AW-1:0]        p0_v;
  logic [ROW_W-1:0]     masked;
  logic [POP8_W-1:0]    p1_cnt [DIGITS];
  logic [ROWCNT_W-1:0]  row_cnt;
  logic [ROWCNT_W-1:0]  p2_cnt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gcao_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  always_comb begin
    n_act   = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
    load_ok = {1'b0, node_a} < CNT_W'(MAX_NODES);
    a_ok    = {1'b0, node_a} < n_act;
    b_ok    = {1'b0, node_b} < n_act;
    for (int i = 0; i < ROW_W; i++) begin
      mask[i] = CNT_W'(i) < n_act;
    end
  end

  // adjacency ram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[node_a[AW-1:0]] <= row_bits;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    mem_we          = 1'b0;
    rd_addr         = node_a[AW-1:0];
    div_req.start   = 1'b0;
    div_req.num     = num_r;
    div_req.den     = den_r;
    out_load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (action == ACT_LOAD) begin
            mem_we     = load_ok;
            state_next = ST_DONE;
          end else if (action == ACT_CLUSTER && a_ok) begin
            state_next = ST_CL_ROW;
          end else if (action == ACT_OVERLAP && a_ok && b_ok) begin
            state_next = ST_OV_ROWA;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CL_ROW: begin
        state_next = ST_CL_WALK;
      end
      ST_CL_WALK: begin
        rd_addr = v;
        if (v == V_LAST) begin
          state_next = ST_CL_DRAIN;
        end
      end
      ST_CL_DRAIN: begin
        if (cnt == DRAIN_LAST) begin
          state_next = ST_CL_FIN;
        end
      end
      ST_CL_FIN: begin
        state_next = ST_DIV_GO;
      end
      ST_OV_ROWA: begin
        rd_addr    = b_r[AW-1:0];
        state_next = ST_OV_ROWB;
      end
      ST_OV_ROWB: begin
        state_next = ST_OV_COUNT;
      end
      ST_OV_COUNT: begin
        if (cnt == DCNT_W'(DIGITS - 1)) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    onehot_a = ROW_W'(1) << a_r;
    pair     = onehot_a | (ROW_W'(1) << b_r);
    rb_c     = rd_data & mask_r & ~pair;
    masked   = rd_data & ROW_W'(nb) & ~(ROW_W'(1) << p0_v);
    deg_m1   = deg - DEG_W'(1);
    prod     = (2*DEG_W)'(deg) * (2*DEG_W)'(deg_m1);
    row_cnt  = '0;
    for (int k = 0; k < DIGITS; k++) begin
      row_cnt = row_cnt + ROWCNT_W'(p1_cnt[k]);
    end
  end

  // neighbor row popcount pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_flag <= 1'b0;
      p1_flag <= 1'b0;
      p2_flag <= 1'b0;
    end else begin
      p0_flag <= (state == ST_CL_WALK) && nb[v];
      p1_flag <= p0_flag;
      p2_flag <= p1_flag;
    end
    p0_v <= v;
    for (int k = 0; k < DIGITS; k++) begin
      p1_cnt[k] <= pop8(masked[k*DIGIT_W +: DIGIT_W]);
    end
    p2_cnt <= row_cnt;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          a_r     <= node_a;
          b_r     <= node_b;
          mask_r  <= mask;
          num_r   <= '0;
          den_r   <= '0;
          ratio_r <= '0;
        end
      end
      ST_CL_ROW: begin
        nb  <= rd_data[MAX_NODES-1:0] & mask_r[MAX_NODES-1:0] & ~onehot_a[MAX_NODES-1:0];
        v   <= '0;
        deg <= '0;
        sum <= '0;
      end
      ST_CL_WALK: begin
        v   <= v + AW'(1);
        deg <= deg + DEG_W'(nb[v]);
        cnt <= '0;
        if (p2_flag) begin
          sum <= sum + SUM_W'(p2_cnt);
        end
      end
      ST_CL_DRAIN: begin
        cnt <= cnt + DCNT_W'(1);
        if (p2_flag) begin
          sum <= sum + SUM_W'(p2_cnt);
        end
      end
      ST_CL_FIN: begin
        if (deg >= DEG_W'(2)) begin
          num_r <= sum[SUM_W-1:1];
          den_r <= NUM_W'(prod >> 1);
        end
      end
      ST_OV_ROWA: begin
        ra <= rd_data & mask_r & ~pair;
      end
      ST_OV_ROWB: begin
        w_and <= ra & rb_c;
        w_or  <= ra | rb_c;
        cnt   <= '0;
      end
      ST_OV_COUNT: begin
        num_r <= num_r + NUM_W'(pop8(w_and[DIGIT_W-1:0]));
        den_r <= den_r + NUM_W'(pop8(w_or[DIGIT_W-1:0]));
        w_and <= w_and >> DIGIT_W;
        w_or  <= w_or >> DIGIT_W;
        cnt   <= cnt + DCNT_W'(1);
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          ratio_r <= div_rsp.quo;
        end
      end
      ST_DIV_GO, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      numerator   <= num_r;
      denominator <= den_r;
      ratio_q16   <= ratio_r;
    end
  end

  `GCAO_ASSERT_NEXT(a_load_done, clk, rst, in_valid && in_ready && action == ACT_LOAD, state == ST_DONE)
  `GCAO_ASSERT_SAME(a_div_state, clk, rst, div_rsp.done, state == ST_DIV)
  `GCAO_ASSERT_SAME(a_num_le_den, clk, rst, state == ST_DIV_GO, num_r <= den_r)

endmodule

### test/tb_graph_clustering_and_overlap.sv
// testbench for graph_clustering_and_overlap: adjacency row loads, clustering and overlap queries
`timescale 1ns / 1ps

module tb_graph_clustering_and_overlap;
  import gcao_pkg::*;

  localparam int MAX_NODES = MAX_NODES_DEF;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AFTER = 150;
  localparam int PHASES = 9;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   den;
    logic [RATIO_W-1:0] ratio;
  } metrics_t;

  typedef struct {
    logic [1:0]        act;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [ROW_W-1:0]  row;
    bit                typed;
    metrics_t          exp;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         action;
  logic [NODE_W-1:0]  node_a;
  logic [NODE_W-1:0]  node_b;
  logic [ROW_W-1:0]   row_bits;
  logic               out_valid;
  logic               out_ready;
  logic [NUM_W-1:0]   numerator;
  logic [NUM_W-1:0]   denominator;
  logic [RATIO_W-1:0] ratio_q16;

  logic [ROW_W-1:0] adj_rows [MAX_NODES];
  logic [CNT_W-1:0] node_limit;
  metrics_t         pending_metrics [$];
  int               mismatches;
  int               results_seen;
  int               quiet_cycles;
  bit               idle_on;
  bit               held_off;

  graph_clustering_and_overlap #(.MAX_NODES(MAX_NODES)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .node_a(node_a), .node_b(node_b), .row_bits(row_bits),
    .out_valid(out_valid), .out_ready(out_ready), .numerator(numerator),
    .denominator(denominator), .ratio_q16(ratio_q16)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned nodes_in_use();
    return (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
  endfunction

  function automatic metrics_t predict_metrics(input logic [1:0] act,
                                               input logic [NODE_W-1:0] a,
                                               input logic [NODE_W-1:0] b,
                                               input logic [ROW_W-1:0] row);
    metrics_t res;
    int unsigned n;
    int unsigned deg;
    int unsigned pairs;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] nbrs;
    logic [ROW_W-1:0] ra;
    logic [ROW_W-1:0] rb;
    logic [ROW_W-1:0] pair_bits;
    longint unsigned q;
    res = '0;
    n = nodes_in_use();
    mask = (n >= ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
    case (act)
      ACT_LOAD: begin
        adj_rows[a] = row;
      end
      ACT_CLUSTER: begin
        if (a < n) begin
          nbrs = adj_rows[a] & mask & ~(64'd1 << a);
          deg = $countones(nbrs);
          if (deg >= 2) begin
            pairs = 0;
            for (int v = 0; v < MAX_NODES; v++) begin
              if (nbrs[v]) pairs += $countones(adj_rows[v] & nbrs & ~(64'd1 << v));
            end
            res.num = NUM_W'(pairs / 2);
            res.den = NUM_W'(deg * (deg - 1) / 2);
          end
        end
      end
      ACT_OVERLAP: begin
        if (a < n && b < n) begin
          pair_bits = (64'd1 << a) | (64'd1 << b);
          ra = adj_rows[a] & mask & ~pair_bits;
          rb = adj_rows[b] & mask & ~pair_bits;
          res.num = NUM_W'($countones(ra & rb));
          res.den = NUM_W'($countones(ra | rb));
        end
      end
      default: ;
    endcase
    if (res.den != 0) begin
      q = (64'(res.num) << FRAC_BITS) / res.den;
      res.ratio = (q > Q_ONE) ? Q_ONE : RATIO_W'(q);
    end
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: r = '0;
      1: r = '1;
      2, 3: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      4, 5: r = r | {$urandom, $urandom};
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] random_node();
    int unsigned n;
    n = nodes_in_use();
    if (n > 0 && $urandom_range(99) < 85) return NODE_W'($urandom_range(n - 1));
    return NODE_W'($urandom_range(MAX_NODES - 1));
  endfunction

  // entered at a falling edge where in_valid has not been driven yet
  task automatic send_item(input logic [1:0] act, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [ROW_W-1:0] row,
                           input bit typed, input metrics_t typed_exp);
    metrics_t want;
    while (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    node_a   <= a;
    node_b   <= b;
    row_bits <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_metrics(act, a, b, row);
    pending_metrics.push_back(typed ? typed_exp : want);
    @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [1:0] act;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    pick = $urandom_range(99);
    if (pick < 25) act = ACT_LOAD;
    else if (pick < 60) act = ACT_CLUSTER;
    else if (pick < 95) act = ACT_OVERLAP;
    else act = ACT_NONE;
    a = random_node();
    b = ($urandom_range(9) == 0) ? a : random_node();
    if (act == ACT_LOAD) a = NODE_W'($urandom_range(MAX_NODES - 1));
    send_item(act, a, b, random_row(), 1'b0, '0);
  endtask

  task automatic set_node_count(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_metrics.size() != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we     <= 1'b0;
    node_limit = value;
  endtask

  // directed items, run with all 64 nodes in use after every row is loaded
  stim_row_t directed [] = '{
    '{ACT_LOAD,    6'd5,  6'd0,  64'h0,                 1'b1, '0},
    '{ACT_CLUSTER, 6'd5,  6'd0,  64'h0,                 1'b1, '0},
    '{ACT_OVERLAP, 6'd5,  6'd5,  64'h0,                 1'b1, '0},
    '{ACT_LOAD,    6'd6,  6'd63, 64'hC0,                1'b1, '0},
    '{ACT_CLUSTER, 6'd6,  6'd0,  64'h0,                 1'b1, '0},
    '{ACT_LOAD,    6'd63, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{ACT_OVERLAP, 6'd63, 6'd63, 64'h0,                 1'b1,
      '{NUM_W'(63), NUM_W'(63), Q_ONE}},
    '{ACT_CLUSTER, 6'd63, 6'd0,  64'h0,                 1'b0, '0},
    '{ACT_LOAD,    6'd0,  6'd0,  64'h5555_5555_5555_5555, 1'b1, '0},
    '{ACT_LOAD,    6'd1,  6'd0,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '0},
    '{ACT_OVERLAP, 6'd0,  6'd1,  64'h0,                 1'b0, '0},
    '{ACT_CLUSTER, 6'd0,  6'd0,  64'h0,                 1'b0, '0},
    '{ACT_NONE,    6'd63, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{ACT_CLUSTER, 6'd63, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{ACT_OVERLAP, 6'd0,  6'd63, 64'h0,                 1'b0, '0},
    '{ACT_OVERLAP, 6'd63, 6'd0,  64'h0,                 1'b0, '0},
    '{ACT_LOAD,    6'd2,  6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{ACT_CLUSTER, 6'd2,  6'd0,  64'h0,                 1'b0, '0},
    '{ACT_OVERLAP, 6'd1,  6'd63, 64'h0,                 1'b0, '0},
    '{ACT_CLUSTER, 6'd1,  6'd0,  64'h0,                 1'b0, '0}
  };

  logic [CNT_W-1:0] phase_count [PHASES] = '{7'd64, 7'd1, 7'd0, 7'd2, 7'd127, 7'd3,
                                             7'd40, 7'd100, 7'd64};
  int phase_items [PHASES] = '{120, 40, 40, 60, 120, 60, 120, 100, 110};

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    action     = ACT_LOAD;
    node_a     = '0;
    node_b     = '0;
    row_bits   = '0;
    node_limit = NODE_COUNT_RST;
    idle_on    = 1'b1;
    mismatches = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int r = 0; r < MAX_NODES; r++) begin
      send_item(ACT_LOAD, NODE_W'(r), NODE_W'($urandom), random_row(), 1'b0, '0);
    end
    foreach (directed[i]) begin
      send_item(directed[i].act, directed[i].a, directed[i].b, directed[i].row,
                directed[i].typed, directed[i].exp);
    end
    for (int p = 0; p < PHASES; p++) begin
      set_node_count(phase_count[p]);
      idle_on = (p != 6);
      repeat (phase_items[p]) send_random();
    end
    in_valid <= 1'b0;
    while (pending_metrics.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_graph_clustering_and_overlap: clean");
    end else begin
      $display("tb_graph_clustering_and_overlap: errors");
    end
    $finish;
  end

  // result side ready, with one long hold-off to back the block up
  initial begin
    out_ready = 1'b0;
    held_off  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 34);
      end
    end
  end

  initial results_seen = 0;

  always @(posedge clk) begin
    metrics_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_metrics.size() == 0) begin
        $error("result item with no item pending");
        mismatches++;
      end else begin
        want = pending_metrics.pop_front();
        if (numerator !== want.num) begin
          $error("numerator expected %0d got %0d", want.num, numerator);
          mismatches++;
        end
        if (denominator !== want.den) begin
          $error("denominator expected %0d got %0d", want.den, denominator);
          mismatches++;
        end
        if (ratio_q16 !== want.ratio) begin
          $error("ratio_q16 expected %0d got %0d", want.ratio, ratio_q16);
          mismatches++;
        end
      end
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb_graph_clustering_and_overlap: errors");
        $finish;
      end
    end
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gcao_pkg.sv
rtl/core/gcao_div.sv
rtl/core/graph_clustering_and_overlap.sv
test/tb_graph_clustering_and_overlap.sv
